/* src/lir_pkg.sv */
// ----------------------------------------------------------------------------
// lir_pkg: shared definitions for the linear interpolation resampler
// Default sizes, rate register reset value, register indexes and the
// status bundle of the serial divider.
// ----------------------------------------------------------------------------
package lir_pkg;

    // default sizes
    localparam int MAX_UP_DEF      = 16;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int RATE_BITS_DEF   = 19;

    // rate register value after reset
    localparam int RATE_RST = 16000;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_IN_RATE  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_RATE = CFG_IDX_BITS'(1);

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } lir_div_stat_t;

endpackage

/* src/lir_div.sv */
// ----------------------------------------------------------------------------
// lir_div: bit-serial restoring divider
// One quotient bit per cycle; a start while busy is ignored. The partial
// remainder may be preloaded; it must be below the divisor. The quotient
// replaces the dividend in its shift register.
// ----------------------------------------------------------------------------
module lir_div
    import lir_pkg::*;
#(
    parameter int QUOT_BITS = SAMPLE_BITS_DEF,
    parameter int DIV_BITS  = RATE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [QUOT_BITS-1:0] dividend,
    input  logic [DIV_BITS-1:0]  rem_init,
    input  logic [DIV_BITS-1:0]  divisor,
    output lir_div_stat_t        stat,
    output logic [QUOT_BITS-1:0] quotient,
    output logic [DIV_BITS-1:0]  remainder
);

    localparam int CNT_BITS = (QUOT_BITS > 1) ? $clog2(QUOT_BITS) : 1;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [CNT_BITS-1:0]  cnt_next;
    logic [QUOT_BITS-1:0] dvd_reg;
    logic [QUOT_BITS-1:0] dvd_next;
    logic [DIV_BITS-1:0]  rem_reg;
    logic [DIV_BITS-1:0]  rem_next;
    logic [DIV_BITS-1:0]  dsr_reg;
    logic [DIV_BITS-1:0]  dsr_next;

    logic [DIV_BITS:0]    trial;
    logic [DIV_BITS:0]    trial_diff;
    logic                 trial_ge;
    logic                 last_step;

    // one restoring step
    assign trial      = {rem_reg, dvd_reg[QUOT_BITS-1]};
    assign trial_ge   = (trial >= {1'b0, dsr_reg});
    assign trial_diff = trial - {1'b0, dsr_reg};
    assign last_step  = (cnt_reg == CNT_BITS'(QUOT_BITS - 1));

    // sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = rem_init;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = trial_ge ? trial_diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
            dvd_next = {dvd_reg[QUOT_BITS-2:0], trial_ge};
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

/* src/linear_interp_resampler.sv */
// ----------------------------------------------------------------------------
// linear_interp_resampler: sample rate converter by linear interpolation
// Items are taken one at a time: in_stall holds the input until the last item
// has emitted all its results. Every division runs on one shared bit-serial
// divider with max(SAMPLE_BITS, RATE_BITS+1) quotient bits.
// Reset (asynchronous, active low) sets both rates to 16000 and closes the
// stream; no clearing pass is needed.
// ----------------------------------------------------------------------------
module linear_interp_resampler
    import lir_pkg::*;
#(
    parameter int MAX_UP      = MAX_UP_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int RATE_BITS   = RATE_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input samples
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SAMPLE_BITS-1:0]  sample_in,
    input  logic                    end_of_stream,
    // output samples
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SAMPLE_BITS-1:0]  sample_out,
    output logic                    final_out,
    output logic                    overrun,
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [RATE_BITS-1:0]    cfg_data
);

    localparam int SB   = SAMPLE_BITS;
    localparam int RB   = RATE_BITS;
    localparam int QW   = (SB > RB + 1) ? SB : RB + 1;
    localparam int PW   = SB + RB;
    localparam int CAP  = 2 * MAX_UP;
    localparam int CW   = $clog2(CAP + 1);
    localparam int MCW  = $clog2(RB + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIV_C  = 4'd1;
    localparam logic [3:0] ST_DIV_S  = 4'd2;
    localparam logic [3:0] ST_EOSCHK = 4'd3;
    localparam logic [3:0] ST_DIV_E  = 4'd4;
    localparam logic [3:0] ST_PLAN   = 4'd5;
    localparam logic [3:0] ST_MUL    = 4'd6;
    localparam logic [3:0] ST_DIV_I  = 4'd7;
    localparam logic [3:0] ST_OUT_I  = 4'd8;
    localparam logic [3:0] ST_EMIT_E = 4'd9;
    localparam logic [3:0] ST_COMMIT = 4'd10;

    // control state
    logic [3:0]    state_reg, state_next;
    logic [RB-1:0] in_rate_reg, in_rate_next;
    logic [RB-1:0] out_rate_reg, out_rate_next;
    logic          have_prev_reg, have_prev_next;
    logic [RB-1:0] phase_reg, phase_next;
    logic [RB:0]   skip_reg, skip_next;
    logic [SB-1:0] prev_reg, prev_next;
    logic          out_valid_reg, out_valid_next;

    // working registers
    logic [SB-1:0]  x_reg, x_next;
    logic           eos_reg, eos_next;
    logic [RB:0]    c_reg, c_next;
    logic [RB:0]    c2_reg, c2_next;
    logic [RB:0]    skip_w_reg, skip_w_next;
    logic [RB-1:0]  phase_w_reg, phase_w_next;
    logic [CW-1:0]  n1_reg, n1_next;
    logic [CW-1:0]  k2_reg, k2_next;
    logic           cut_reg, cut_next;
    logic [RB-1:0]  pos_reg, pos_next;
    logic [SB-1:0]  mag_reg, mag_next;
    logic           neg_reg, neg_next;
    logic [SB-1:0]  mul_hi_reg, mul_hi_next;
    logic [RB-1:0]  mul_lo_reg, mul_lo_next;
    logic [MCW-1:0] mul_cnt_reg, mul_cnt_next;
    logic [SB-1:0]  res_reg, res_next;
    logic [SB-1:0]  out_sample_reg, out_sample_next;
    logic           out_final_reg, out_final_next;
    logic           out_overrun_reg, out_overrun_next;
    logic           out_load;

    // divider connection
    logic          div_start;
    logic [QW-1:0] div_dividend;
    logic [RB-1:0] div_rem_init;
    logic [RB-1:0] div_divisor;
    lir_div_stat_t div_stat;
    logic [QW-1:0] div_quot;
    logic [RB-1:0] div_rem;

    // handshakes
    logic in_acc;
    logic cfg_acc;
    logic slot_free;
    logic rates_ok;

    // arithmetic
    logic [RB:0]     span_cur;
    logic [RB:0]     span_w;
    logic [RB:0]     total;
    logic [RB:0]     pos_step;
    logic [SB:0]     diff;
    logic [SB:0]     diff_neg;
    logic [SB:0]     mul_sum;
    logic [PW-1:0]   product;
    logic [SB:0]     q_round;
    logic [SB:0]     delta;
    logic [SB:0]     interp_full;
    logic [CW-1:0]   n1_calc;
    logic [CW-1:0]   room;
    logic [CW-1:0]   k2_calc;
    logic            cut_calc;

    lir_div #(
        .QUOT_BITS (QW),
        .DIV_BITS  (RB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .rem_init  (div_rem_init),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // handshake terms
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE) || cfg_valid;
    assign in_acc    = in_valid && !in_stall;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign slot_free = !out_valid_reg || !out_stall;
    assign rates_ok  = (in_rate_reg != '0) && (out_rate_reg != '0);

    // output positions still to reach in this interval: numerators of the ceil divide
    assign span_cur = {1'b0, out_rate_reg} - {1'b0, phase_reg} + {1'b0, in_rate_reg}
                      - (RB+1)'(1);
    assign span_w   = {1'b0, out_rate_reg} - {1'b0, phase_w_reg} + {1'b0, in_rate_reg}
                      - (RB+1)'(1);
    // position after the last output of the interval: phase + c*in
    assign total    = {1'b0, out_rate_reg} + {1'b0, in_rate_reg} - (RB+1)'(1)
                      - {1'b0, div_rem};
    assign pos_step = {1'b0, pos_reg} + {1'b0, in_rate_reg};

    // difference between the two neighbouring samples, as sign and magnitude
    assign diff     = {x_reg[SB-1], x_reg} - {prev_reg[SB-1], prev_reg};
    assign diff_neg = -diff;

    // shift-add multiplier step, one phase bit per cycle
    assign mul_sum  = {1'b0, mul_hi_reg} + (mul_lo_reg[0] ? {1'b0, mag_reg} : '0);
    assign product  = {mul_hi_reg, mul_lo_reg};

    // floor of the signed quotient, added to the earlier sample
    assign q_round     = {1'b0, div_quot[SB-1:0]} + {{SB{1'b0}}, (div_rem != '0)};
    assign delta       = neg_reg ? -q_round : {1'b0, div_quot[SB-1:0]};
    assign interp_full = {prev_reg[SB-1], prev_reg} + delta;

    // result counts under the per-item cap
    assign n1_calc  = (c_reg > (RB+1)'(CAP)) ? CW'(CAP) : c_reg[CW-1:0];
    assign room     = CW'(CAP) - n1_calc;
    assign k2_calc  = (c2_reg > (RB+1)'(room)) ? room : c2_reg[CW-1:0];
    assign cut_calc = (c_reg > (RB+1)'(CAP)) || (c2_reg > (RB+1)'(room));

    // divider operand selection
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = QW'(span_cur);
        div_rem_init = '0;
        div_divisor  = in_rate_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && rates_ok && have_prev_reg && (skip_reg == '0))
                begin
                    div_start = 1'b1;
                end
            end
            ST_DIV_C:
            begin
                div_dividend = QW'(total);
                div_divisor  = out_rate_reg;
                div_start    = div_stat.done;
            end
            ST_EOSCHK:
            begin
                div_dividend = QW'(span_w);
                div_start    = eos_reg && (skip_w_reg == '0);
            end
            ST_MUL:
            begin
                div_dividend = product[QW-1:0];
                div_rem_init = RB'(product >> QW);
                div_divisor  = out_rate_reg;
                div_start    = (mul_cnt_reg == MCW'(RB));
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        in_rate_next     = in_rate_reg;
        out_rate_next    = out_rate_reg;
        have_prev_next   = have_prev_reg;
        phase_next       = phase_reg;
        skip_next        = skip_reg;
        prev_next        = prev_reg;
        x_next           = x_reg;
        eos_next         = eos_reg;
        c_next           = c_reg;
        c2_next          = c2_reg;
        skip_w_next      = skip_w_reg;
        phase_w_next     = phase_w_reg;
        n1_next          = n1_reg;
        k2_next          = k2_reg;
        cut_next         = cut_reg;
        pos_next         = pos_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        mul_hi_next      = mul_hi_reg;
        mul_lo_next      = mul_lo_reg;
        mul_cnt_next     = mul_cnt_reg;
        res_next         = res_reg;
        out_load         = 1'b0;
        out_sample_next  = out_sample_reg;
        out_final_next   = out_final_reg;
        out_overrun_next = out_overrun_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // a rate write closes the stream
                if (cfg_acc && ((cfg_index == REG_IN_RATE) || (cfg_index == REG_OUT_RATE)))
                begin
                    if (cfg_index == REG_IN_RATE)
                    begin
                        in_rate_next = cfg_data;
                    end
                    else
                    begin
                        out_rate_next = cfg_data;
                    end
                    have_prev_next = 1'b0;
                    phase_next     = '0;
                    skip_next      = '0;
                    prev_next      = '0;
                end
                else if (in_acc && rates_ok)
                begin
                    x_next   = sample_in;
                    eos_next = end_of_stream;
                    c_next   = '0;
                    c2_next  = '0;
                    if (!have_prev_reg)
                    begin
                        skip_w_next  = '0;
                        phase_w_next = '0;
                        state_next   = ST_EOSCHK;
                    end
                    else if (skip_reg != '0)
                    begin
                        skip_w_next  = skip_reg - (RB+1)'(1);
                        phase_w_next = phase_reg;
                        state_next   = ST_EOSCHK;
                    end
                    else
                    begin
                        state_next = ST_DIV_C;
                    end
                end
            end

            ST_DIV_C:
            begin
                // count of outputs in this interval
                if (div_stat.done)
                begin
                    c_next     = div_quot[RB:0];
                    state_next = ST_DIV_S;
                end
            end

            ST_DIV_S:
            begin
                // new whole part and phase
                if (div_stat.done)
                begin
                    skip_w_next  = div_quot[RB:0] - (RB+1)'(1);
                    phase_w_next = div_rem;
                    state_next   = ST_EOSCHK;
                end
            end

            ST_EOSCHK:
            begin
                if (eos_reg && (skip_w_reg == '0))
                begin
                    state_next = ST_DIV_E;
                end
                else
                begin
                    state_next = ST_PLAN;
                end
            end

            ST_DIV_E:
            begin
                // count of tail outputs held at the last sample
                if (div_stat.done)
                begin
                    c2_next    = div_quot[RB:0];
                    state_next = ST_PLAN;
                end
            end

            ST_PLAN:
            begin
                n1_next      = n1_calc;
                k2_next      = k2_calc;
                cut_next     = cut_calc;
                pos_next     = phase_reg;
                neg_next     = diff[SB];
                mag_next     = diff[SB] ? diff_neg[SB-1:0] : diff[SB-1:0];
                mul_hi_next  = '0;
                mul_lo_next  = phase_reg;
                mul_cnt_next = '0;
                if (n1_calc != '0)
                begin
                    state_next = ST_MUL;
                end
                else if (k2_calc != '0)
                begin
                    state_next = ST_EMIT_E;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end

            ST_MUL:
            begin
                if (mul_cnt_reg == MCW'(RB))
                begin
                    state_next = ST_DIV_I;
                end
                else
                begin
                    {mul_hi_next, mul_lo_next} = {mul_sum, mul_lo_reg[RB-1:1]};
                    mul_cnt_next = mul_cnt_reg + MCW'(1);
                end
            end

            ST_DIV_I:
            begin
                if (div_stat.done)
                begin
                    res_next   = interp_full[SB-1:0];
                    state_next = ST_OUT_I;
                end
            end

            ST_OUT_I:
            begin
                // hand one interpolated result to the output register
                if (slot_free)
                begin
                    out_load         = 1'b1;
                    out_sample_next  = res_reg;
                    out_final_next   = eos_reg && (n1_reg == CW'(1)) && (k2_reg == '0);
                    out_overrun_next = cut_reg;
                    n1_next          = n1_reg - CW'(1);
                    if (n1_reg != CW'(1))
                    begin
                        pos_next     = pos_step[RB-1:0];
                        mul_hi_next  = '0;
                        mul_lo_next  = pos_step[RB-1:0];
                        mul_cnt_next = '0;
                        state_next   = ST_MUL;
                    end
                    else if (k2_reg != '0)
                    begin
                        state_next = ST_EMIT_E;
                    end
                    else
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end

            ST_EMIT_E:
            begin
                // tail results repeat the last sample
                if (slot_free)
                begin
                    out_load         = 1'b1;
                    out_sample_next  = x_reg;
                    out_final_next   = (k2_reg == CW'(1));
                    out_overrun_next = cut_reg;
                    k2_next          = k2_reg - CW'(1);
                    if (k2_reg == CW'(1))
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end

            ST_COMMIT:
            begin
                if (eos_reg)
                begin
                    have_prev_next = 1'b0;
                    phase_next     = '0;
                    skip_next      = '0;
                    prev_next      = '0;
                end
                else
                begin
                    have_prev_next = 1'b1;
                    phase_next     = phase_w_reg;
                    skip_next      = skip_w_reg;
                    prev_next      = x_reg;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_rate_reg   <= RB'(RATE_RST);
            out_rate_reg  <= RB'(RATE_RST);
            have_prev_reg <= 1'b0;
            phase_reg     <= '0;
            skip_reg      <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_rate_reg   <= in_rate_next;
            out_rate_reg  <= out_rate_next;
            have_prev_reg <= have_prev_next;
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg           <= x_next;
        eos_reg         <= eos_next;
        c_reg           <= c_next;
        c2_reg          <= c2_next;
        skip_w_reg      <= skip_w_next;
        phase_w_reg     <= phase_w_next;
        n1_reg          <= n1_next;
        k2_reg          <= k2_next;
        cut_reg         <= cut_next;
        pos_reg         <= pos_next;
        mag_reg         <= mag_next;
        neg_reg         <= neg_next;
        mul_hi_reg      <= mul_hi_next;
        mul_lo_reg      <= mul_lo_next;
        mul_cnt_reg     <= mul_cnt_next;
        res_reg         <= res_next;
        out_sample_reg  <= out_sample_next;
        out_final_reg   <= out_final_next;
        out_overrun_reg <= out_overrun_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;
    assign final_out  = out_final_reg;
    assign overrun    = out_overrun_reg;

`ifndef SYNTHESIS
    // the divider only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> ((state_reg == ST_DIV_C) || (state_reg == ST_DIV_S) ||
                           (state_reg == ST_DIV_E) || (state_reg == ST_DIV_I)))
        else $error("divider finished outside a wait state");

    // an interpolated result is only offered while some remain
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT_I) |-> (n1_reg != '0))
        else $error("interpolated result with no count left");

    // end of stream closes the stream
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_COMMIT) && eos_reg) |=> !have_prev_reg)
        else $error("stream still open after end of stream");

    // the stored phase stays below the target rate
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && (out_rate_reg != '0)) |-> (phase_reg < out_rate_reg))
        else $error("phase not below target rate");
`endif

endmodule
